>>> sv/glw_pkg.sv
package glw_pkg;

  // grid geometry
  localparam int GRID_SIZE   = 32;
  localparam int MAX_RESULTS = 34;
  localparam int COORD_W     = 7;
  localparam int CELL_W      = 5;
  localparam int IDX_W       = $clog2(GRID_SIZE);
  localparam int CELLS       = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // stream packing
  localparam int IN_FIELDS_W  = 4 * COORD_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * CELL_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COORD_W-1:0] mag_t;
  typedef logic signed [COORD_W+1:0] err_t;

  localparam coord_t GRID_LIM = COORD_W'(GRID_SIZE);

  // one classified item, ready for the walker
  typedef struct packed {
    logic              trace;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_val;
    logic              steep;
    coord_t            a0;
    coord_t            a1;
    coord_t            b0;
    mag_t              dminor;
    mag_t              dmajor;
    logic              dir_neg;
    logic              bstep_neg;
  } glw_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } glw_qstat_t;

  typedef struct packed {
    logic clearing;
    logic closing;
    logic emit;
    logic emit_hit;
  } glw_bstat_t;

  function automatic logic in_grid(coord_t r, coord_t c);
    return (r >= 0) && (r < GRID_LIM) && (c >= 0) && (c < GRID_LIM);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(coord_t r, coord_t c);
    return ADDR_W'(r[IDX_W-1:0]) * ADDR_W'(GRID_SIZE) + ADDR_W'(c[IDX_W-1:0]);
  endfunction

  function automatic mag_t abs_diff(coord_t x, coord_t y);
    logic signed [COORD_W:0] d;
    d = COORD_W'(0) + ({x[COORD_W-1], x} - {y[COORD_W-1], y});
    return d[COORD_W] ? mag_t'(-d) : mag_t'(d);
  endfunction

endpackage

>>> sv/glw_front.sv
module glw_front import glw_pkg::*; (
  input  logic                 kind_i,
  input  logic [IN_DATA_W-1:0] data_i,
  output glw_cmd_t             cmd_o
);

  coord_t r0, c0, r1, c1;
  logic   wall;
  mag_t   dr, dc;
  logic   steep;
  coord_t a0, a1, b0, b1;
  logic   wr_in;

  assign r0   = data_i[COORD_W-1:0];
  assign c0   = data_i[2*COORD_W-1:COORD_W];
  assign r1   = data_i[3*COORD_W-1:2*COORD_W];
  assign c1   = data_i[4*COORD_W-1:3*COORD_W];
  assign wall = data_i[4*COORD_W];

  assign dr    = abs_diff(r1, r0);
  assign dc    = abs_diff(c1, c0);
  assign steep = dr > dc;

  // rows lead on steep lines, columns otherwise
  assign a0 = steep ? r0 : c0;
  assign a1 = steep ? r1 : c1;
  assign b0 = steep ? c0 : r0;
  assign b1 = steep ? c1 : r1;

  assign wr_in = in_grid(r0, c0);

  always_comb begin
    cmd_o           = '0;
    cmd_o.trace     = kind_i;
    cmd_o.wr_en     = !kind_i && wr_in;
    cmd_o.wr_addr   = wr_in ? cell_addr(r0, c0) : '0;
    cmd_o.wr_val    = wall;
    cmd_o.steep     = steep;
    cmd_o.a0        = a0;
    cmd_o.a1        = a1;
    cmd_o.b0        = b0;
    cmd_o.dminor    = steep ? dc : dr;
    cmd_o.dmajor    = steep ? dr : dc;
    cmd_o.dir_neg   = a0 > a1;
    cmd_o.bstep_neg = !(b0 < b1);
  end

endmodule

>>> sv/glw_queue.sv
module glw_queue import glw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  glw_cmd_t   cmd_i,
  input  logic       pop_i,
  output glw_cmd_t   cmd_o,
  output glw_qstat_t stat_o
);

  glw_cmd_t               slot_q [Q_DEPTH];
  logic     [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic     [Q_CNT_W-1:0] cnt_q;
  logic                   do_push, do_pop;

  assign stat_o.full  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/glw_back.sv
module glw_back import glw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glw_cmd_t              cmd_i,
  input  glw_qstat_t            qstat_i,
  output logic                  pop_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_user_o,
  output logic                  out_last_o,
  output glw_bstat_t            stat_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_CLOSE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic              wall_mem_q [CELLS];
  logic              rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic [ADDR_W-1:0] clr_q;

  coord_t            a_q, a_d, b_q, b_d;
  err_t              err_q, err_d, err_m;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              steep_q, dir_neg_q, bstep_neg_q;
  coord_t            a1_q;
  mag_t              dminor_q, dmajor_q;
  logic              load;

  coord_t            row_q, col_q, row_d, col_d;
  logic              steep_d, cur_in, nxt_in, at_end, slot_free;
  coord_t            a_nx, b_nx;
  err_t              err_nx;

  logic              emit, emit_last, emit_hit;
  logic              ovalid_q;
  logic [CELL_W-1:0] orow_q, ocol_q;
  logic              ohit_q, ouser_q, olast_q;

  assign row_q     = steep_q ? a_q : b_q;
  assign col_q     = steep_q ? b_q : a_q;
  assign cur_in    = in_grid(row_q, col_q);
  assign at_end    = a_q == a1_q;
  assign slot_free = !ovalid_q || out_ready_i;

  // one bresenham step
  always_comb begin
    a_nx   = dir_neg_q ? a_q - coord_t'(1) : a_q + coord_t'(1);
    err_m  = err_q - $signed({2'b00, dminor_q});
    b_nx   = b_q;
    err_nx = err_m;
    if (err_m < 0) begin
      b_nx   = bstep_neg_q ? b_q - coord_t'(1) : b_q + coord_t'(1);
      err_nx = err_m + $signed({2'b00, dmajor_q});
    end
  end

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    load      = 1'b0;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_hit  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.trace) begin
            load    = 1'b1;
            a_d     = cmd_i.a0;
            b_d     = cmd_i.b0;
            err_d   = $signed({3'b000, cmd_i.dmajor[COORD_W-1:1]});
            cnt_d   = '0;
            state_d = ST_WALK;
          end else begin
            mem_we    = cmd_i.wr_en;
            mem_waddr = cmd_i.wr_addr;
            mem_wdata = cmd_i.wr_val;
          end
        end
      end
      ST_WALK: begin
        if (at_end) begin
          state_d = ST_CLOSE;
        end else if (cur_in) begin
          if (slot_free) begin
            emit     = 1'b1;
            emit_hit = rd_q;
            cnt_d    = cnt_q + CNT_W'(1);
            if (rd_q || cnt_q == CNT_W'(MAX_RESULTS - 2)) begin
              state_d = ST_CLOSE;
            end else begin
              a_d   = a_nx;
              b_d   = b_nx;
              err_d = err_nx;
            end
          end
        end else begin
          a_d   = a_nx;
          b_d   = b_nx;
          err_d = err_nx;
        end
      end
      ST_CLOSE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // wall bit of the cell that sits in the position registers next cycle
  assign steep_d = load ? cmd_i.steep : steep_q;
  assign row_d   = steep_d ? a_d : b_d;
  assign col_d   = steep_d ? b_d : a_d;
  assign nxt_in  = in_grid(row_d, col_d);
  assign rd_addr = nxt_in ? cell_addr(row_d, col_d) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wall_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= wall_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    err_q <= err_d;
    cnt_q <= cnt_d;
    if (load) begin
      steep_q     <= cmd_i.steep;
      a1_q        <= cmd_i.a1;
      dminor_q    <= cmd_i.dminor;
      dmajor_q    <= cmd_i.dmajor;
      dir_neg_q   <= cmd_i.dir_neg;
      bstep_neg_q <= cmd_i.bstep_neg;
    end
    if (emit) begin
      orow_q  <= emit_last ? '0 : row_q[CELL_W-1:0];
      ocol_q  <= emit_last ? '0 : col_q[CELL_W-1:0];
      ohit_q  <= emit_hit;
      ouser_q <= !emit_last;
      olast_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = OUT_DATA_W'({ohit_q, ocol_q, orow_q});
  assign out_user_o  = ouser_q;
  assign out_last_o  = olast_q;

  assign stat_o.clearing = state_q == ST_CLEAR;
  assign stat_o.closing  = state_q == ST_CLOSE;
  assign stat_o.emit     = emit;
  assign stat_o.emit_hit = emit_hit;

endmodule

>>> sv/grid_line_of_sight_walker_top.sv
// channel  | dir | beat contents
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | tuser: kind; tdata: start_row, start_col, end_row, end_col,
//          |     |   wall_value (lowest bits first)
// m_axis   | out | tuser: cell_valid; tdata: cell_row, cell_col, hit_wall;
//          |     |   tlast: closing marker of a trace
//
// a write item leaves the queue and updates the wall map from idle; a trace is loaded, then
// walks one major-axis step at a time (up to |major delta| steps, off-grid steps included),
// moves to the closing state at the end cell, which it does not emit, then sends the closing
// marker; the walker loop and its single memory read port set the pace of a trace
// after reset a clearing pass zeroes all GRID_SIZE squared (1024) cells of the wall map,
// one cell a cycle, with s_axis_tready low meanwhile
// a two-deep command queue keeps s_axis moving while the walker waits on m_axis
module grid_line_of_sight_walker_top import glw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // start_row, start_col, end_row, end_col, wall_value
  input  logic                  s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // cell_row, cell_col, hit_wall
  output logic                  m_axis_tuser,  // cell_valid
  output logic                  m_axis_tlast
);

  glw_cmd_t   front_cmd, head_cmd;
  glw_qstat_t qstat;
  glw_bstat_t bstat;
  logic       push, pop;

  // no item enters while the wall map is being cleared
  assign s_axis_tready = !qstat.full && !bstat.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;

  // classify the beat: wall write or line setup
  glw_front u_front (
    .kind_i (s_axis_tuser),
    .data_i (s_axis_tdata),
    .cmd_o  (front_cmd)
  );

  // decouples intake from the walker
  glw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (qstat)
  );

  // wall map, bresenham walker and output register
  glw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .stat_o      (bstat)
  );

  // nothing leaves the block during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.clearing |-> !m_axis_tvalid)
    else $error("output beat during clearing pass");

  // a wall cell always ends the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.emit && bstat.emit_hit |=> bstat.closing)
    else $error("walk went on past a wall");

  // the closing marker carries no cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && m_axis_tdata == '0)
    else $error("closing marker carries cell data");

  // queue occupancy stays consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

endmodule
